>>> src/drps_pkg.sv
package drps_pkg;

    localparam int CURVE_POINTS = 4;
    localparam int PT_IDX_W     = $clog2(2 * CURVE_POINTS);
    localparam int PC_IDX_W     = $clog2(2 * (CURVE_POINTS + 1));
    localparam int SEG_W        = $clog2(CURVE_POINTS + 1);

    localparam logic [11:0] DUTY_FULL = 12'd4095;

    localparam logic [1:0] CFG_FERT_SP  = 2'd0;
    localparam logic [1:0] CFG_SEED_SP  = 2'd1;
    localparam logic [1:0] CFG_HA_DIST  = 2'd2;
    localparam logic [1:0] CFG_CAL_TOUT = 2'd3;

    localparam logic [1:0] CAL_NONE = 2'd0;
    localparam logic [1:0] CAL_FERT = 2'd1;
    localparam logic [1:0] CAL_SEED = 2'd2;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        table_material;
        logic [2:0]  table_index;
        logic [31:0] table_amount;
        logic [7:0]  table_percent;
        logic        operating;
        logic        machine_stopped;
        logic [7:0]  speed_kmh;
        logic [1:0]  calib_mode;
        logic [7:0]  calib_percent;
        logic [15:0] calib_elapsed;
    } t_in_item;

    typedef struct packed {
        logic [11:0] fert_pwm;
        logic [11:0] seed_pwm;
        logic        calib_expired;
    } t_out_item;

    // datapath micro operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,      // capture item, start per-meter division for material
        OP_VEL,       // latch per-meter quotient and speed*1000/60
        OP_MUL,       // amount per minute = per-meter * velocity
        OP_SEG_RD,    // issue table reads for current segment
        OP_SEG_CHK,   // compare against segment point
        OP_MAP_MUL,   // product of offsets
        OP_MAP_DIV,   // start interpolation division
        OP_MAP_END,   // offset low duty by quotient, store channel result
        OP_SAT,       // saturate above top point
        OP_CALIB      // calibration or idle result
    } t_op;

    typedef struct packed {
        t_op  op;
        logic mat;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic seg_hit;
        logic seg_last;
        logic mpm_zero;
        logic degenerate;
    } t_sts;

    // divide by 100 through a reciprocal multiply (exact over the whole 20-bit range)
    function automatic logic [11:0] pct_to_duty(input logic [7:0] pct);
        logic [19:0] p;
        logic [39:0] q;
        p = 20'(pct) * 20'd4095;
        q = 40'(p) * 40'd671089;
        if (pct > 8'd100) return 12'd0;
        return q[37:26];
    endfunction

endpackage

>>> src/drps_div.sv
module drps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [47:0] o_quo
);
    logic [47:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;

    always_comb begin
        n_trial = {r_rem[31:0], r_quo[47]} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd48;
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!n_trial[32]) begin
                r_rem <= n_trial;
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_quo[47]};
                r_quo <= {r_quo[46:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

>>> src/drps_datapath.sv
module drps_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drps_pkg::t_cmd     i_cmd,
    output drps_pkg::t_sts     o_sts,
    input  drps_pkg::t_in_item i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output drps_pkg::t_out_item o_res
);
    logic [15:0] r_fert_sp, r_seed_sp, r_dist, r_tout;
    logic [31:0] r_amt [2 * drps_pkg::CURVE_POINTS];
    logic [7:0]  r_pct [2 * (drps_pkg::CURVE_POINTS + 1)];
    logic [31:0] r_mpm, r_pm, r_vel, r_lo, r_hi;
    logic [11:0] r_dlo, r_dhi, r_fert, r_seed;
    logic [drps_pkg::SEG_W-1:0] r_seg;
    logic [47:0] r_prod;
    logic        r_exp, r_mat;
    logic        div_start;
    logic [47:0] div_num, div_quo;
    logic [31:0] div_den;
    logic        div_busy;
    logic [drps_pkg::PT_IDX_W-1:0] amt_i;
    logic [drps_pkg::PC_IDX_W-1:0] pct_i;
    logic [11:0] d_res, d_cal;
    logic [12:0] dd;
    logic        wr_ok;
    logic [13:0] vel_x;
    logic [29:0] vel_p;

    drps_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num), .i_den(div_den),
        .o_busy(div_busy), .o_quo(div_quo)
    );

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 32'd1;
        unique case (i_cmd.op)
            drps_pkg::OP_LOAD: begin
                div_start = 1'b1;
                div_num = 48'((i_cmd.mat ? r_seed_sp : r_fert_sp)) * 48'd1000;
                div_den = (r_dist == 16'd0) ? 32'd1 : 32'(r_dist);
            end
            drps_pkg::OP_MAP_DIV: begin
                div_start = 1'b1;
                div_num = r_prod;
                div_den = r_hi - r_lo;
            end
            default: ;
        endcase
    end

    // speed*1000/60 = speed*50/3, divide by 3 via reciprocal multiply
    assign vel_x = 14'(i_item.speed_kmh) * 14'd50;
    assign vel_p = 30'(vel_x) * 30'd43691;

    assign amt_i = drps_pkg::PT_IDX_W'(32'(r_mat) * drps_pkg::CURVE_POINTS + 32'(r_seg));
    assign pct_i = drps_pkg::PC_IDX_W'(32'(r_mat) * (drps_pkg::CURVE_POINTS + 1)
                                       + 32'(r_seg) + 1);
    // interpolated duty with sign of segment slope
    assign dd = (r_dhi >= r_dlo) ? 13'(r_dlo) + 13'(div_quo[11:0])
                                 : 13'(r_dlo) - 13'(div_quo[11:0]);
    assign d_res = dd[11:0];
    assign d_cal = drps_pkg::pct_to_duty(i_item.calib_percent);
    assign wr_ok = i_item.table_index <= 3'(drps_pkg::CURVE_POINTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fert_sp <= '0; r_seed_sp <= '0; r_dist <= '0; r_tout <= '0;
            for (int k = 0; k < 2 * drps_pkg::CURVE_POINTS; k++) r_amt[k] <= '0;
            for (int k = 0; k < 2 * (drps_pkg::CURVE_POINTS + 1); k++) r_pct[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    drps_pkg::CFG_FERT_SP:  r_fert_sp <= i_cfg_data;
                    drps_pkg::CFG_SEED_SP:  r_seed_sp <= i_cfg_data;
                    drps_pkg::CFG_HA_DIST:  r_dist    <= i_cfg_data;
                    drps_pkg::CFG_CAL_TOUT: r_tout    <= i_cfg_data;
                endcase
            end
            if (i_cmd.op == drps_pkg::OP_LOAD && i_item.kind == drps_pkg::KIND_POINT && wr_ok) begin
                r_pct[drps_pkg::PC_IDX_W'(32'(i_item.table_material)
                      * (drps_pkg::CURVE_POINTS + 1) + 32'(i_item.table_index))]
                    <= i_item.table_percent;
                if (i_item.table_index != 3'd0)
                    r_amt[drps_pkg::PT_IDX_W'(32'(i_item.table_material)
                          * drps_pkg::CURVE_POINTS + 32'(i_item.table_index) - 1)]
                        <= i_item.table_amount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            drps_pkg::OP_LOAD: begin
                r_mat <= i_cmd.mat;
                r_exp <= 1'b0;
                if (!i_cmd.mat) begin
                    r_fert <= '0;
                    r_seed <= '0;
                end
            end
            drps_pkg::OP_VEL: begin
                r_pm  <= (r_dist == 16'd0) ? 32'd1 : div_quo[31:0];
                r_vel <= 32'(vel_p[29:17]);
            end
            drps_pkg::OP_MUL: begin
                r_mpm <= r_pm * r_vel;
                r_seg <= '0;
                r_lo  <= '0;
                r_dlo <= drps_pkg::pct_to_duty(
                    r_pct[drps_pkg::PC_IDX_W'(32'(r_mat) * (drps_pkg::CURVE_POINTS + 1))]);
            end
            drps_pkg::OP_SEG_RD: begin
                r_hi  <= r_amt[amt_i];
                r_dhi <= drps_pkg::pct_to_duty(r_pct[pct_i]);
            end
            drps_pkg::OP_SEG_CHK: begin
                if (!o_sts.seg_hit) begin
                    r_lo  <= r_hi;
                    r_dlo <= r_dhi;
                    r_seg <= r_seg + 1'b1;
                end
            end
            drps_pkg::OP_MAP_MUL: begin
                r_prod <= 48'(r_mpm - r_lo) * 48'((r_dhi >= r_dlo) ? r_dhi - r_dlo
                                                                   : r_dlo - r_dhi);
            end
            drps_pkg::OP_MAP_END: begin
                if (r_mpm == 32'd0) begin
                    if (r_mat) r_seed <= '0; else r_fert <= '0;
                end else if (r_hi <= r_lo) begin
                    if (r_mat) r_seed <= r_dhi; else r_fert <= r_dhi;
                end else begin
                    if (r_mat) r_seed <= d_res; else r_fert <= d_res;
                end
            end
            drps_pkg::OP_SAT: begin
                // top point duty holds above the curve
                if (r_mat) r_seed <= r_dhi; else r_fert <= r_dhi;
            end
            drps_pkg::OP_CALIB: begin
                r_fert <= '0;
                r_seed <= '0;
                r_exp  <= 1'b0;
                if (i_item.operating == 1'b0 && (i_item.calib_mode == drps_pkg::CAL_FERT
                        || i_item.calib_mode == drps_pkg::CAL_SEED)) begin
                    r_exp <= i_item.calib_elapsed >= r_tout;
                    if (i_item.calib_mode == drps_pkg::CAL_FERT)
                        r_fert <= (i_item.calib_elapsed >= r_tout) ? 12'd0 : d_cal;
                    else
                        r_seed <= (i_item.calib_elapsed >= r_tout) ? 12'd0 : d_cal;
                end
            end
            default: ;
        endcase
    end

    assign o_sts = '{div_busy:   div_busy,
                     seg_hit:    r_mpm <= r_hi,
                     seg_last:   r_seg == drps_pkg::SEG_W'(drps_pkg::CURVE_POINTS - 1),
                     mpm_zero:   r_mpm == 32'd0,
                     degenerate: r_hi <= r_lo};
    assign o_res = '{fert_pwm: r_fert, seed_pwm: r_seed, calib_expired: r_exp};
endmodule

>>> src/drps_ctrl.sv
module drps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_kind,
    input  logic               i_run,
    output logic               o_ready,
    input  drps_pkg::t_sts     i_sts,
    output drps_pkg::t_cmd     o_cmd,
    output logic               o_valid,
    input  logic               i_out_ready
);
    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_DIV2, S_MUL, S_RD, S_CHK, S_MMUL, S_MDIV, S_WAIT,
        S_END, S_CAL, S_OUT
    } t_state;

    t_state r_state;
    logic   r_mat, r_valid;

    always_comb begin
        o_cmd = '{op: drps_pkg::OP_NOP, mat: r_mat};
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                o_cmd.op  = drps_pkg::OP_LOAD;
                o_cmd.mat = 1'b0;
            end
            S_DIV1: if (!i_sts.div_busy) o_cmd.op = drps_pkg::OP_VEL;
            S_MUL:  if (!i_sts.div_busy) o_cmd.op = drps_pkg::OP_MUL;
            S_RD:   o_cmd.op = drps_pkg::OP_SEG_RD;
            S_CHK:  o_cmd.op = i_sts.mpm_zero ? drps_pkg::OP_MAP_END
                             : (!i_sts.seg_hit && i_sts.seg_last) ? drps_pkg::OP_SAT
                             : drps_pkg::OP_SEG_CHK;
            S_MMUL: o_cmd.op = drps_pkg::OP_MAP_MUL;
            S_MDIV: o_cmd.op = drps_pkg::OP_MAP_DIV;
            S_END:  if (!i_sts.div_busy) o_cmd.op = drps_pkg::OP_MAP_END;
            S_CAL:  o_cmd.op = drps_pkg::OP_CALIB;
            S_OUT:  if (!r_mat) begin
                o_cmd.op  = drps_pkg::OP_LOAD;
                o_cmd.mat = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mat   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_mat <= 1'b0;
                    if (i_kind == drps_pkg::KIND_POINT) r_state <= S_IDLE;
                    else if (i_run) r_state <= S_DIV1;
                    else r_state <= S_CAL;
                end
                S_DIV1: if (!i_sts.div_busy) r_state <= S_MUL;
                S_MUL:  if (!i_sts.div_busy) r_state <= S_RD;
                S_RD:   r_state <= S_CHK;
                S_CHK: begin
                    if (i_sts.mpm_zero || (!i_sts.seg_hit && i_sts.seg_last))
                        r_state <= S_OUT;
                    else if (i_sts.seg_hit) r_state <= S_MMUL;
                    else r_state <= S_RD;
                end
                S_MMUL: r_state <= S_MDIV;
                S_MDIV: r_state <= S_WAIT;
                S_WAIT: r_state <= S_END;
                S_END:  if (!i_sts.div_busy) r_state <= S_OUT;
                S_CAL: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    if (r_mat) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_mat   <= 1'b1;
                        r_state <= S_DIV1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
endmodule

>>> src/dual_rate_pwm_setpoint.sv
// Dual-channel PWM setpoint: each accepted control tick yields one transfer carrying the
// fertilizer and seed duty values (0..4095); a calibration point write yields none. In
// operation, each channel runs a per-meter division, a velocity step (constant reciprocal
// multiply), a multiply, a walk over up to CURVE_POINTS curve segments and, unless its
// amount is zero or it saturates, one interpolation division; the divisions share a
// single 48-step shift/subtract divider. A new item is taken only once the previous
// result has been transferred. The curve store is in flip-flops and clears at reset.
module dual_rate_pwm_setpoint (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drps_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output drps_pkg::t_out_item o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    drps_pkg::t_cmd     cmd;
    drps_pkg::t_sts     sts;
    drps_pkg::t_in_item r_item;
    drps_pkg::t_in_item item;
    logic               run;

    // hold the accepted item for the whole computation
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_item <= i_data;
    end
    assign item = (i_valid && o_ready) ? i_data : r_item;
    // operating and moving: curve path, otherwise calibration/idle path
    assign run = i_data.operating && !i_data.machine_stopped;

    assign o_cfg_ready = 1'b1;

    drps_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid, .i_kind(i_data.kind), .i_run(run), .o_ready,
        .i_sts(sts), .o_cmd(cmd), .o_valid, .i_out_ready(i_ready)
    );

    drps_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(cmd), .o_sts(sts), .i_item(item),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_res(o_data)
    );

    // a result never appears while a new item is being taken
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("item taken while result pending");
    // a point write never raises a result
    a_point_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.kind == drps_pkg::KIND_POINT) |=> !o_valid)
        else $error("point write produced a result");
    // expiry only flagged with zero duties
    a_exp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.calib_expired) |-> (o_data.fert_pwm == 12'd0
        && o_data.seed_pwm == 12'd0)) else $error("expired with non-zero duty");
endmodule
